[design/adts_frame_seek_indexer_defines.svh]
// ----------------------------------------------------------------------------
// adts_frame_seek_indexer_defines
// assertion macros shared by the seek indexer
// ----------------------------------------------------------------------------
`ifndef ADTS_FRAME_SEEK_INDEXER_DEFINES_SVH
`define ADTS_FRAME_SEEK_INDEXER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AFSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AFSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/afsi_pkg.sv]
// ----------------------------------------------------------------------------
// afsi_pkg
// types and constants of the adts frame seek indexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afsi_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hff;
  localparam logic [7:0] SYNC_MASK    = 8'hf6;
  localparam logic [7:0] SYNC_VALUE   = 8'hf0;
  localparam logic [7:0] VERSION_MASK = 8'h08;
  localparam logic [1:0] LEN_HI_MASK  = 2'h3;
  localparam logic [12:0] HEADER_LEN  = 13'd8;
  localparam logic [2:0] HDR_LAST_POS = 3'd7;
  localparam logic [2:0] HDR_STORED   = 3'd6;
  localparam logic [7:0] FPE_RESET    = 8'd43;

  localparam logic CFG_START_OFFSET     = 1'b0;
  localparam logic CFG_FRAMES_PER_ENTRY = 1'b1;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] position;
    logic [23:0] entry_index;
    logic [23:0] entries_total;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

[design/adts_frame_seek_indexer.sv]
// ----------------------------------------------------------------------------
// adts_frame_seek_indexer
// scans an adts byte stream, emits seek entries and an end-of-scan summary
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  in       | in_valid, in_stall, in_data     | sink
//  out      | out_valid, out_stall, out_data  | source
//  cfg      | cfg_write, cfg_index, cfg_data  | sink
//
//  one byte per cycle while in_stall is low; each byte is parsed in the cycle it is accepted and
//  its results land in a three-slot output queue, visible the next cycle.
//  a byte gives at most two beats (entry and summary at end of scan).
//  in_stall rises only when two or more beats wait in the queue.
//  rst is synchronous; it clears the scan and restores register defaults.
//  after the summary every accepted byte is dropped until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adts_frame_seek_indexer
  import afsi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] start_offset;
  logic [7:0]  frames_per_entry;

  logic [31:0] byte_offset, byte_offset_next;
  logic [7:0]  header_store [HDR_STORED];
  logic [2:0]  header_bytes_seen, header_bytes_seen_next;
  logic [12:0] skip_left, skip_left_next;
  logic        first_frame_done, first_frame_done_next;
  logic        version_bit, version_bit_next;
  logic [7:0]  frames_in_entry, frames_in_entry_next;
  logic [23:0] entry_count, entry_count_next;
  logic [31:0] frame_start, frame_start_next;
  logic        scan_stopped, scan_stopped_next;

  out_item_t   queue [3];
  out_item_t   queue_next [3];
  logic [1:0]  count, count_next;

  logic        accept, pop, work;
  logic        make_entry, make_summary;
  logic        sync_ok, is_stop;
  logic [12:0] flen;
  logic [7:0]  fie_cur;
  logic [1:0]  base;
  out_item_t   res0, res1;
  logic        push0, push1;

  assign in_stall  = count > 2'd1;
  assign accept    = in_valid && !in_stall;
  assign work      = accept && !scan_stopped;
  assign out_valid = count != 2'd0;
  assign out_data  = queue[0];
  assign pop       = out_valid && !out_stall;

  // byte parser
  always_comb begin
    byte_offset_next       = byte_offset;
    header_bytes_seen_next = header_bytes_seen;
    skip_left_next         = skip_left;
    first_frame_done_next  = first_frame_done;
    version_bit_next       = version_bit;
    frames_in_entry_next   = frames_in_entry;
    entry_count_next       = entry_count;
    frame_start_next       = frame_start;
    scan_stopped_next      = scan_stopped;
    make_entry             = 1'b0;
    is_stop                = 1'b0;
    sync_ok = (header_store[0] == SYNC_BYTE) &&
              ((header_store[1] & SYNC_MASK) == SYNC_VALUE);
    if (!first_frame_done) begin
      version_bit_next = (header_store[1] & VERSION_MASK) != 8'd0;
    end
    if (version_bit_next) begin
      flen = {header_store[3][1:0] & LEN_HI_MASK, header_store[4], header_store[5][7:5]};
    end else begin
      flen = {header_store[4], header_store[5][7:3]};
    end
    fie_cur = (frames_in_entry >= frames_per_entry) ? 8'd0 : frames_in_entry;

    if (work) begin
      byte_offset_next = byte_offset + 32'd1;
      if (skip_left != 13'd0) begin
        skip_left_next = skip_left - 13'd1;
      end else begin
        if (header_bytes_seen == 3'd0) begin
          frame_start_next = byte_offset;
        end
        if (header_bytes_seen != HDR_LAST_POS) begin
          header_bytes_seen_next = header_bytes_seen + 3'd1;
        end else begin
          header_bytes_seen_next = 3'd0;
          if (!sync_ok) begin
            is_stop = 1'b1;
          end else begin
            first_frame_done_next = 1'b1;
            make_entry            = fie_cur == 8'd0;
            if (make_entry) begin
              entry_count_next = entry_count + 24'd1;
            end
            frames_in_entry_next = fie_cur + 8'd1;
            if (flen < HEADER_LEN) begin
              is_stop = 1'b1;
            end else begin
              skip_left_next = flen - HEADER_LEN;
            end
          end
        end
      end
    end
    // without a valid header the version bit stays put
    if (!(work && skip_left == 13'd0 && header_bytes_seen == HDR_LAST_POS && sync_ok)) begin
      version_bit_next = version_bit;
    end
    make_summary = work && (is_stop || in_data.last_byte);
    if (make_summary) begin
      scan_stopped_next = 1'b1;
    end
  end

  // result beats
  always_comb begin
    res1               = '0;
    res1.kind          = KIND_SUMMARY;
    res1.entries_total = entry_count_next;
    res1.last          = 1'b1;
    if (make_entry) begin
      res0             = '0;
      res0.kind        = KIND_ENTRY;
      res0.position    = frame_start_next + start_offset;
      res0.entry_index = entry_count;
      res0.last        = !make_summary;
    end else begin
      res0 = res1;
    end
    push0 = make_entry || make_summary;
    push1 = make_entry && make_summary;
  end

  // output queue, slot zero drives the port
  always_comb begin
    base = count - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (pop) begin
        queue_next[i] = (i < 2) ? queue[i + 1] : queue[i];
      end else begin
        queue_next[i] = queue[i];
      end
      if (push0 && base == 2'(i)) begin
        queue_next[i] = res0;
      end
      if (push1 && (base + 2'd1) == 2'(i)) begin
        queue_next[i] = res1;
      end
    end
    count_next = base + {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset      <= 32'd0;
      frames_per_entry  <= FPE_RESET;
      byte_offset       <= 32'd0;
      header_bytes_seen <= 3'd0;
      skip_left         <= 13'd0;
      first_frame_done  <= 1'b0;
      version_bit       <= 1'b0;
      frames_in_entry   <= 8'd0;
      entry_count       <= 24'd0;
      frame_start       <= 32'd0;
      scan_stopped      <= 1'b0;
      count             <= 2'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_START_OFFSET:     start_offset     <= cfg_data;
          CFG_FRAMES_PER_ENTRY: frames_per_entry <= cfg_data[7:0];
          default: ;
        endcase
      end
      byte_offset       <= byte_offset_next;
      header_bytes_seen <= header_bytes_seen_next;
      skip_left         <= skip_left_next;
      first_frame_done  <= first_frame_done_next;
      version_bit       <= version_bit_next;
      frames_in_entry   <= frames_in_entry_next;
      entry_count       <= entry_count_next;
      frame_start       <= frame_start_next;
      scan_stopped      <= scan_stopped_next;
      count             <= count_next;
    end
  end

  // header bytes and queue payload carry no reset
  always_ff @(posedge clk) begin
    if (work && skip_left == 13'd0 && header_bytes_seen < HDR_STORED) begin
      header_store[header_bytes_seen] <= in_data.data_byte;
    end
    for (int i = 0; i < 3; i++) begin
      queue[i] <= queue_next[i];
    end
  end

`include "adts_frame_seek_indexer_defines.svh"

  `AFSI_ASSERT_NOW(a_queue_bound, count == 2'd3, !accept || scan_stopped, "queue overfilled")
  `AFSI_ASSERT_NEXT(a_stopped_quiet, scan_stopped, count <= $past(count), "beat after stop")
  `AFSI_ASSERT_NOW(a_summary_last, out_valid && out_data.kind == KIND_SUMMARY, out_data.last, "summary without last")
  `AFSI_ASSERT_NOW(a_skip_header, skip_left != 13'd0, header_bytes_seen == 3'd0, "skip inside header")

endmodule

`default_nettype wire
